// ===== rtl/brf_pkg.sv =====
// brf_pkg: bank codes, command codes, mode constants and banking helpers
// for the banked register file; no dependencies
package brf_pkg;

    typedef enum logic [2:0] {
        BANK_USR,
        BANK_FIQ,
        BANK_IRQ,
        BANK_SVC,
        BANK_ABT,
        BANK_UND
    } bank_t;

    localparam logic [2:0] CMD_READ        = 3'd0;
    localparam logic [2:0] CMD_WRITE       = 3'd1;
    localparam logic [2:0] CMD_SET_STATUS  = 3'd2;
    localparam logic [2:0] CMD_SET_SAVE    = 3'd3;
    localparam logic [2:0] CMD_EXCEPTION   = 3'd4;
    localparam logic [2:0] CMD_WRITE_SAVED = 3'd5;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam logic [31:0] STATUS_RESET  = 32'h0000_00D3;
    localparam logic [31:0] STATUS_T_MODE = 32'h0000_003F;
    localparam logic [31:0] STATUS_I      = 32'h0000_0080;

    // register memory layout: user r0-r15, fiq r8-r14, then sp/lr pairs
    localparam int REG_DEPTH   = 31;
    localparam int SAVED_DEPTH = 5;
    localparam logic [4:0] FIQ_BASE   = 5'd16;
    localparam logic [4:0] SPLR_BASE  = 5'd23;
    localparam logic [3:0] REG_LR     = 4'd14;
    localparam logic [4:0] ADDR_PC    = 5'd15;

    function automatic bank_t bank_for_mode(input logic [4:0] mode, input bank_t cur);
        bank_t b;
        begin
            case (mode)
                MODE_USR, MODE_SYS: b = BANK_USR;
                MODE_FIQ:           b = BANK_FIQ;
                MODE_IRQ:           b = BANK_IRQ;
                MODE_SVC:           b = BANK_SVC;
                MODE_ABT:           b = BANK_ABT;
                MODE_UND:           b = BANK_UND;
                default:            b = cur;
            endcase
            return b;
        end
    endfunction

    function automatic logic bank_has_saved(input bank_t b);
        logic h;
        begin
            case (b)
                BANK_FIQ, BANK_IRQ, BANK_SVC, BANK_ABT, BANK_UND: h = 1'b1;
                default:                                         h = 1'b0;
            endcase
            return h;
        end
    endfunction

    // saved word slot: fiq 0 .. und 4
    function automatic logic [2:0] saved_addr(input bank_t b);
        return 3'(b) - 3'd1;
    endfunction

    function automatic logic [4:0] reg_addr(input logic [3:0] r, input bank_t b);
        logic [2:0] b_off;
        logic [4:0] a;
        begin
            b_off = 3'(b) - 3'(BANK_IRQ);
            if (r[3] && (r != 4'd15) && (b == BANK_FIQ))
                a = FIQ_BASE + {2'b00, r[2:0]};
            else if (((r == 4'd13) || (r == 4'd14)) && (b == BANK_IRQ || b == BANK_SVC
                     || b == BANK_ABT || b == BANK_UND))
                a = SPLR_BASE + {2'b00, b_off[1:0], ~r[0]};
            else
                a = {1'b0, r};
            return a;
        end
    endfunction

    // exception vector / 4 selects the mode entered
    function automatic logic [4:0] vector_mode(input logic [2:0] idx);
        logic [4:0] m;
        begin
            case (idx)
                3'd0:    m = MODE_SVC;
                3'd1:    m = MODE_UND;
                3'd2:    m = MODE_SVC;
                3'd3:    m = MODE_ABT;
                3'd4:    m = MODE_ABT;
                3'd5:    m = MODE_SVC;
                3'd6:    m = MODE_IRQ;
                3'd7:    m = MODE_FIQ;
                default: m = MODE_SVC;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/banked_register_file_mode_switch.sv =====
// banked_register_file_mode_switch: status word register, with banked general
// registers and saved status words in two synchronous memories; depends on brf_pkg
//
// sequence: S_OP, then S_SAVED and S_LOAD, which waits for the output register;
//   exception entry inserts S_EXC_LINK and S_EXC_PC (two extra register memory
//   writes: link, then pc); a new word is taken in S_IDLE only, once the last one
//   is in the output register; the registered memory reads set the sequence
// reset: asynchronous, active low; status 0xD3 (supervisor), all registers and
//   saved words read as zero through per-entry valid bits
module banked_register_file_mode_switch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [3:0]  reg_index,
    input  logic [31:0] value,
    input  logic [4:0]  exception_vector,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [31:0] status_word,
    output logic [31:0] saved_status,
    output logic        has_saved,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import brf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_EXC_LINK,
        S_EXC_PC,
        S_SAVED,
        S_LOAD
    } state_t;

    state_t state_reg;

    // latched input word
    logic [2:0]  cmd_reg;
    logic [3:0]  idx_reg;
    logic [31:0] value_reg;
    logic [4:0]  vec_reg;

    logic [31:0] status_reg;
    bank_t       bank_reg;
    logic [31:0] exception_base_reg;
    logic        link_adj_reg;
    logic [31:0] rd_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] read_data_reg;
    logic [31:0] status_word_reg;
    logic [31:0] saved_status_reg;
    logic        has_saved_reg;
    logic        out_load;

    // register memory: user, fiq and sp/lr banks in one array
    logic [31:0]          rf_mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] rf_valid_reg;
    logic [31:0]          rf_rdata_reg;
    logic                 rf_rvalid_reg;
    logic                 rf_we;
    logic [4:0]           rf_waddr;
    logic [31:0]          rf_wdata;
    logic [4:0]           rf_raddr;
    logic [31:0]          rf_rd;

    // saved status memory: fiq, irq, svc, abt, und
    logic [31:0]            sv_mem [SAVED_DEPTH];
    logic [SAVED_DEPTH-1:0] sv_valid_reg;
    logic [31:0]            sv_rdata_reg;
    logic                   sv_rvalid_reg;
    logic                   sv_we;
    logic [2:0]             sv_waddr;
    logic [31:0]            sv_wdata;
    logic [2:0]             sv_raddr;

    // status update shared by status writes and exception entry
    logic [31:0] exc_status;
    logic [31:0] status_in;
    bank_t       new_bank;
    logic        is_status_cmd;
    logic        save_old;
    logic [31:0] pc_next;

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign status_word  = status_word_reg;
    assign saved_status = saved_status_reg;
    assign has_saved    = has_saved_reg;

    // result word moves into the output register when it is free
    assign out_load = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);

    // entries never written read as zero
    assign rf_rd = rf_rvalid_reg ? rf_rdata_reg : 32'd0;

    // exception entry: set I, clear T and mode, insert the vector's mode
    assign exc_status = (status_reg & ~STATUS_T_MODE) | STATUS_I
                        | {27'd0, vector_mode(vec_reg[4:2])};
    assign status_in  = (cmd_reg == CMD_EXCEPTION) ? exc_status : value_reg;

    // bank swaps only on a change of the mode bits; unknown modes keep it
    assign new_bank = (status_in[4:0] != status_reg[4:0])
                      ? bank_for_mode(status_in[4:0], bank_reg) : bank_reg;

    assign is_status_cmd = (cmd_reg == CMD_SET_STATUS) || (cmd_reg == CMD_SET_SAVE)
                           || (cmd_reg == CMD_EXCEPTION);
    assign save_old      = (cmd_reg != CMD_SET_STATUS);

    // vector pc, word aligned, plus the prefetch offset
    assign pc_next = ((exception_base_reg + {27'd0, vec_reg}) & ~32'd3) + 32'd4;

    // memory port control per sequencer step
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = reg_addr(idx_reg, bank_reg);
        rf_wdata = value_reg;
        rf_raddr = reg_addr(idx_reg, bank_reg);
        sv_we    = 1'b0;
        sv_waddr = saved_addr(bank_reg);
        sv_wdata = value_reg;
        sv_raddr = saved_addr(bank_reg);
        case (state_reg)
            S_OP:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    rf_we = 1'b1;
                end
                if (cmd_reg == CMD_EXCEPTION)
                begin
                    rf_raddr = ADDR_PC;
                end
                if (is_status_cmd)
                begin
                    // except for a plain status write, old status goes to the new bank's saved word
                    sv_we    = save_old && bank_has_saved(new_bank);
                    sv_waddr = saved_addr(new_bank);
                    sv_wdata = status_reg;
                end
                if (cmd_reg == CMD_WRITE_SAVED)
                begin
                    sv_we = bank_has_saved(bank_reg);
                end
            end
            S_EXC_LINK:
            begin
                // link from the pc read in the previous step, bank already switched
                rf_we    = 1'b1;
                rf_waddr = reg_addr(REG_LR, bank_reg);
                rf_wdata = rf_rd + {30'd0, link_adj_reg, 1'b0};
            end
            S_EXC_PC:
            begin
                rf_we    = 1'b1;
                rf_waddr = ADDR_PC;
                rf_wdata = pc_next;
            end
            default:
            begin
                rf_we = 1'b0;
            end
        endcase
    end

    // register memory, registered read
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        rf_rdata_reg <= rf_mem[rf_raddr];
    end

    // saved status memory, registered read
    always_ff @(posedge clk)
    begin
        if (sv_we)
        begin
            sv_mem[sv_waddr] <= sv_wdata;
        end
        sv_rdata_reg <= sv_mem[sv_raddr];
    end

    // sequencer, control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            status_reg         <= STATUS_RESET;
            bank_reg           <= BANK_SVC;
            exception_base_reg <= 32'd0;
            rf_valid_reg       <= '0;
            sv_valid_reg       <= '0;
            rf_rvalid_reg      <= 1'b0;
            sv_rvalid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            link_adj_reg       <= 1'b0;
            cmd_reg            <= CMD_READ;
            idx_reg            <= '0;
            value_reg          <= '0;
            vec_reg            <= '0;
            rd_reg             <= '0;
            read_data_reg      <= '0;
            status_word_reg    <= '0;
            saved_status_reg   <= '0;
            has_saved_reg      <= 1'b0;
        end
        else
        begin
            rf_rvalid_reg <= rf_valid_reg[rf_raddr];
            sv_rvalid_reg <= sv_valid_reg[sv_raddr];
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (sv_we)
            begin
                sv_valid_reg[sv_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                exception_base_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd;
                        idx_reg   <= reg_index;
                        value_reg <= value;
                        vec_reg   <= exception_vector;
                        state_reg <= S_OP;
                    end
                end
                S_OP:
                begin
                    if (is_status_cmd)
                    begin
                        status_reg   <= status_in;
                        bank_reg     <= new_bank;
                        // link gets +2 when the saved word has T set
                        link_adj_reg <= bank_has_saved(new_bank) && status_reg[5];
                    end
                    state_reg <= (cmd_reg == CMD_EXCEPTION) ? S_EXC_LINK : S_SAVED;
                end
                S_EXC_LINK:
                begin
                    state_reg <= S_EXC_PC;
                end
                S_EXC_PC:
                begin
                    state_reg <= S_SAVED;
                end
                S_SAVED:
                begin
                    // register read issued in S_OP lands here
                    rd_reg    <= (cmd_reg == CMD_READ) ? rf_rd : 32'd0;
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (out_load)
                    begin
                        read_data_reg    <= rd_reg;
                        status_word_reg  <= status_reg;
                        has_saved_reg    <= bank_has_saved(bank_reg);
                        saved_status_reg <= (bank_has_saved(bank_reg) && sv_rvalid_reg)
                                            ? sv_rdata_reg : 32'd0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/brf_checker.sv =====
// brf_checker: port level assertions for banked_register_file_mode_switch,
// bound to the top level; no package dependency
module brf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic [31:0] status_word,
    input logic [31:0] saved_status,
    input logic        has_saved
);

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // no result can appear the cycle after an accept when none was pending
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result shown too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(status_word) && $stable(saved_status))
        else $error("stalled result word changed");

    // banks without a saved word report zero
    a_saved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_saved |-> saved_status == 32'd0)
        else $error("saved status nonzero without saved word");

endmodule

bind banked_register_file_mode_switch brf_checker u_brf_checker (.*);
